FILE: hw/rtl/tcis_pkg.sv
// Shared types, constants and helpers for the toy CPU instruction step core.
package tcis_pkg;

   localparam int MEM_WORDS = 256;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int REG_COUNT = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);

   localparam logic [REG_AW-1:0] PC_IDX = REG_AW'(15);
   localparam logic [REG_AW-1:0] LR_IDX = REG_AW'(14);

   localparam logic [15:0] LDR_ADDR_MAX = 16'd1023;
   localparam logic [7:0]  LDR_REG_MAX  = 8'd15;

   localparam logic [2:0] FLAG_Z  = 3'b001;
   localparam logic [2:0] FLAG_LT = 3'b010;
   localparam logic [2:0] FLAG_GT = 3'b100;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EXEC  = 1'b1;

   localparam logic [7:0] OP_LDI = 8'd0;
   localparam logic [7:0] OP_LDX = 8'd1;
   localparam logic [7:0] OP_LDR = 8'd2;
   localparam logic [7:0] OP_STR = 8'd3;
   localparam logic [7:0] OP_ADD = 8'd4;
   localparam logic [7:0] OP_SUB = 8'd5;
   localparam logic [7:0] OP_MUL = 8'd6;
   localparam logic [7:0] OP_DIV = 8'd7;
   localparam logic [7:0] OP_CMP = 8'd8;
   localparam logic [7:0] OP_B   = 8'd9;
   localparam logic [7:0] OP_BL  = 8'd10;
   localparam logic [7:0] OP_BEQ = 8'd11;
   localparam logic [7:0] OP_BNE = 8'd12;
   localparam logic [7:0] OP_BLT = 8'd13;
   localparam logic [7:0] OP_BGT = 8'd14;
   localparam logic [7:0] OP_MOV = 8'd15;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  mem_word_addr;
      logic [31:0] mem_word_data;
   } tcis_req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [2:0]  flags_out;
      logic        reg_write_valid;
      logic [3:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        fault;
      logic        halted;
   } tcis_rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } tcis_md_ctl_type;

   // Word index of a byte address.
   function automatic logic [MEM_AW-1:0] byte_to_index(input logic [31:0] addr);
      logic [31:0] w;
      w = addr >> 2;
      return w[MEM_AW-1:0];
   endfunction

   // Word index of a write item address, taken modulo the memory depth.
   function automatic logic [MEM_AW-1:0] word_to_index(input logic [7:0] addr);
      logic [31:0] w;
      w = 32'(addr);
      return w[MEM_AW-1:0];
   endfunction

endpackage

FILE: hw/rtl/toy_cpu_instruction_step_core.sv
// Top level of the toy CPU instruction step core.
// An item is accepted when start is high and busy is low. A write item stores
// mem_word_data into the word memory; an execute item fetches the instruction at
// the program counter and runs it. Each item gives exactly one result, shown on
// rsp_data for one cycle with rsp_valid high; the receiver cannot stall it.
// Write items, and execute items while halted, finish in the idle state; other
// instructions pass through fetch read, register read and execute, LDX and
// LDR without a fault add a data read, and MUL and DIV wait for tcis_muldiv.
// The word memory and the register file are synchronous RAMs with registered
// reads, and the fetch, operand read and data read follow one another; the
// divider produces one quotient bit per cycle. Items are taken one at a time:
// busy rises only for execute items and drops in their result cycle.
// Reset clears registers, flags and the halt state at once; the register file
// reads as zero through per-entry valid bits, so no clearing pass is needed.
// The word memory is not cleared and must be written before it is read.
module toy_cpu_instruction_step_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcis_pkg::tcis_req_type req_data,
   output logic                  rsp_valid,
   output tcis_pkg::tcis_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_MEM,
      S_MD
   } state_type;

   state_type state_ff;

   logic [31:0] pc_ff;
   logic [2:0]  flags_ff;
   logic        halt_ff;
   logic [31:0] inst_ff;
   logic        rsp_valid_ff;
   tcis_pkg::tcis_rsp_type rsp_ff;

   // Word memory.
   logic [31:0] mem [tcis_pkg::MEM_WORDS];
   logic [31:0] mem_rd_ff;
   logic [tcis_pkg::MEM_AW-1:0] mem_raddr, mem_waddr;
   logic [31:0] mem_wdata;
   logic        mem_we;

   // Register file with reset valid bits.
   logic [31:0] rf [tcis_pkg::REG_COUNT];
   logic [tcis_pkg::REG_COUNT-1:0] rf_vld_ff;
   logic [31:0] rf_rd0_ff, rf_rd1_ff;
   logic        rf_v0_ff, rf_v1_ff;
   logic [tcis_pkg::REG_AW-1:0] rf_ra0, rf_ra1, rf_ra0_ff, rf_ra1_ff;

   logic        accept;
   logic [31:0] dec_inst;
   logic [7:0]  op, fa, fb;
   logic [15:0] imm;
   logic [tcis_pkg::REG_AW-1:0] ra;
   logic [31:0] opa, opb, ldx_addr;
   logic        ldr_bad;

   tcis_pkg::tcis_md_ctl_type md_ctl;
   logic        md_done;
   logic [31:0] md_result, md_num, md_den;

   logic        fin, fin_wr, fin_fault, fin_halt;
   logic [tcis_pkg::REG_AW-1:0] fin_idx;
   logic [31:0] fin_val, fin_npc;
   logic [2:0]  fin_flags;
   logic        wr_eff;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign op  = inst_ff[31:24];
   assign fa  = inst_ff[23:16];
   assign fb  = inst_ff[15:8];
   assign imm = inst_ff[15:0];
   assign ra  = fa[tcis_pkg::REG_AW-1:0];

   // Register 15 reads as the program counter.
   assign opa = (rf_ra0_ff == tcis_pkg::PC_IDX) ? pc_ff : (rf_v0_ff ? rf_rd0_ff : 32'd0);
   assign opb = (rf_ra1_ff == tcis_pkg::PC_IDX) ? pc_ff : (rf_v1_ff ? rf_rd1_ff : 32'd0);
   assign ldx_addr = opb + 32'(fb);
   assign ldr_bad  = (imm > tcis_pkg::LDR_ADDR_MAX) || (fa > tcis_pkg::LDR_REG_MAX);

   assign dec_inst = mem_rd_ff;
   assign rf_ra0 = (dec_inst[31:24] == tcis_pkg::OP_STR) ?
                   dec_inst[16 +: tcis_pkg::REG_AW] : dec_inst[8 +: tcis_pkg::REG_AW];
   assign rf_ra1 = dec_inst[0 +: tcis_pkg::REG_AW];

   // Memory port selection.
   always_comb begin
      mem_raddr = tcis_pkg::byte_to_index(pc_ff);
      mem_we    = 1'b0;
      mem_waddr = tcis_pkg::word_to_index(req_data.mem_word_addr);
      mem_wdata = req_data.mem_word_data;
      if (state_ff == S_EXEC) begin
         if (op == tcis_pkg::OP_LDX) begin
            mem_raddr = tcis_pkg::byte_to_index(ldx_addr);
         end else begin
            mem_raddr = tcis_pkg::byte_to_index(32'(imm));
         end
         if (op == tcis_pkg::OP_STR) begin
            mem_we    = 1'b1;
            mem_waddr = tcis_pkg::byte_to_index(32'(imm));
            mem_wdata = opa;
         end
      end else if (accept && req_data.req_type == tcis_pkg::REQ_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_eff) begin
         rf[fin_idx] <= fin_val;
      end
      rf_rd0_ff <= rf[rf_ra0];
      rf_rd1_ff <= rf[rf_ra1];
   end

   assign md_ctl.start  = (state_ff == S_EXEC) &&
                          (op == tcis_pkg::OP_MUL || op == tcis_pkg::OP_DIV);
   assign md_ctl.is_div = (op == tcis_pkg::OP_DIV);
   assign md_num = md_ctl.is_div ? opb : opa;
   assign md_den = md_ctl.is_div ? opa : opb;

   tcis_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .num    (md_num),
      .den    (md_den),
      .done   (md_done),
      .result (md_result)
   );

   // Completion of an item.
   always_comb begin
      fin       = 1'b0;
      fin_wr    = 1'b0;
      fin_idx   = ra;
      fin_val   = 32'd0;
      fin_npc   = pc_ff;
      fin_flags = flags_ff;
      fin_fault = 1'b0;
      fin_halt  = halt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.req_type == tcis_pkg::REQ_WRITE || halt_ff)) begin
               fin = 1'b1;
            end
         end
         S_EXEC: begin
            fin     = 1'b1;
            fin_npc = pc_ff + 32'd4;
            case (op)
               tcis_pkg::OP_LDI: begin
                  fin_wr  = 1'b1;
                  fin_val = 32'(imm);
               end
               tcis_pkg::OP_LDX: fin = 1'b0;
               tcis_pkg::OP_LDR: begin
                  if (ldr_bad) begin
                     fin_fault = 1'b1;
                     fin_halt  = 1'b1;
                     fin_npc   = pc_ff;
                  end else begin
                     fin = 1'b0;
                  end
               end
               tcis_pkg::OP_ADD: begin
                  fin_wr  = 1'b1;
                  fin_val = opa + opb;
               end
               tcis_pkg::OP_SUB: begin
                  fin_wr  = 1'b1;
                  fin_val = opa - opb;
               end
               tcis_pkg::OP_MUL, tcis_pkg::OP_DIV: fin = 1'b0;
               tcis_pkg::OP_CMP: begin
                  if (opa == opb) begin
                     fin_flags = tcis_pkg::FLAG_Z;
                  end else if ($signed(opa) < $signed(opb)) begin
                     fin_flags = tcis_pkg::FLAG_LT;
                  end else begin
                     fin_flags = tcis_pkg::FLAG_GT;
                  end
               end
               tcis_pkg::OP_B: fin_npc = 32'(imm);
               tcis_pkg::OP_BL: begin
                  fin_wr  = 1'b1;
                  fin_idx = tcis_pkg::LR_IDX;
                  fin_val = pc_ff + 32'd4;
                  fin_npc = 32'(imm);
               end
               tcis_pkg::OP_BEQ: if ((flags_ff & tcis_pkg::FLAG_Z) != 3'd0) fin_npc = 32'(imm);
               tcis_pkg::OP_BNE: if ((flags_ff & tcis_pkg::FLAG_Z) == 3'd0) fin_npc = 32'(imm);
               tcis_pkg::OP_BLT: if ((flags_ff & tcis_pkg::FLAG_LT) != 3'd0) fin_npc = 32'(imm);
               tcis_pkg::OP_BGT: if ((flags_ff & tcis_pkg::FLAG_GT) != 3'd0) fin_npc = 32'(imm);
               tcis_pkg::OP_MOV: begin
                  fin_wr  = 1'b1;
                  fin_val = opb;
               end
               default: ;
            endcase
         end
         S_MEM: begin
            fin     = 1'b1;
            fin_wr  = 1'b1;
            fin_val = mem_rd_ff;
            fin_npc = pc_ff + 32'd4;
         end
         S_MD: begin
            fin     = md_done;
            fin_wr  = 1'b1;
            fin_val = md_result;
            fin_npc = pc_ff + 32'd4;
         end
         default: ;
      endcase
   end

   // A write to the program counter register is overridden by the new pc.
   assign wr_eff = fin && fin_wr && (fin_idx != tcis_pkg::PC_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 32'd0;
         flags_ff     <= 3'd0;
         halt_ff      <= 1'b0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin;
         if (wr_eff) begin
            rf_vld_ff[fin_idx] <= 1'b1;
         end
         if (fin) begin
            state_ff <= S_IDLE;
            if (state_ff != S_IDLE) begin
               pc_ff    <= fin_npc;
               flags_ff <= fin_flags;
               halt_ff  <= fin_halt;
            end
         end else begin
            case (state_ff)
               S_IDLE:   if (accept) state_ff <= S_DECODE;
               S_DECODE: state_ff <= S_EXEC;
               S_EXEC: begin
                  if (op == tcis_pkg::OP_MUL || op == tcis_pkg::OP_DIV) begin
                     state_ff <= S_MD;
                  end else begin
                     state_ff <= S_MEM;
                  end
               end
               S_MEM:    state_ff <= S_IDLE;
               S_MD:     state_ff <= S_MD;
               default:  state_ff <= S_IDLE;
            endcase
         end
      end
      if (state_ff == S_DECODE) begin
         inst_ff <= dec_inst;
      end
      rf_ra0_ff <= rf_ra0;
      rf_ra1_ff <= rf_ra1;
      rf_v0_ff  <= rf_vld_ff[rf_ra0];
      rf_v1_ff  <= rf_vld_ff[rf_ra1];
      if (fin) begin
         rsp_ff.next_pc         <= (state_ff == S_IDLE) ? pc_ff : fin_npc;
         rsp_ff.flags_out       <= fin_flags;
         rsp_ff.reg_write_valid <= wr_eff;
         rsp_ff.reg_write_index <= wr_eff ? fin_idx : 4'd0;
         rsp_ff.reg_write_value <= wr_eff ? fin_val : 32'd0;
         rsp_ff.fault           <= fin_fault;
         rsp_ff.halted          <= fin_halt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/tcis_muldiv.sv
// Multiply (registered) and iterative signed divide (one quotient bit per cycle).
module tcis_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  tcis_pkg::tcis_md_ctl_type ctl,
   input  logic [31:0]              num,
   input  logic [31:0]              den,
   output logic                     done,
   output logic [31:0]              result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [31:0] res_ff, res_in;
   logic [32:0] rem_sh;
   logic [31:0] num_mag, den_mag;

   assign num_mag = num[31] ? (32'd0 - num) : num;
   assign den_mag = den[31] ? (32'd0 - den) : den;
   assign rem_sh  = {rem_ff[31:0], quo_ff[31]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (ctl.start) begin
         if (!ctl.is_div) begin
            res_in  = 32'(num * den);
            done_in = 1'b1;
         end else if (den == 32'd0) begin
            res_in  = 32'd0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = 6'd0;
            rem_in  = 33'd0;
            quo_in  = num_mag;
            den_in  = den_mag;
            neg_in  = num[31] ^ den[31];
         end
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (32'd0 - quo_in) : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: hw/rtl/tcis_checker.sv
// Port-level checks for the toy CPU instruction step core, bound to the top level.
module tcis_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input tcis_pkg::tcis_rsp_type rsp_data
);

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> rsp_data.halted)
      else $error("fault reported without halt");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_write_valid |->
         rsp_data.reg_write_index == 4'd0 && rsp_data.reg_write_value == 32'd0)
      else $error("register write fields not cleared");

   a_no_pc_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_write_valid |-> rsp_data.reg_write_index != 4'd15)
      else $error("write to program counter reported");

   a_idle_at_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result shown");

   // The slowest item, a divide, bounds the window in which a result must follow acceptance.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##[1:36] rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind toy_cpu_instruction_step_core tcis_checker u_tcis_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
